/* hw/rtl/chg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chg_pkg
// Shared widths, codes, reset values and lane/merge types for the core
// hotplug governor.
// ----------------------------------------------------------------------------
package chg_pkg;

  localparam int LOAD_W   = 7;
  localparam int FREQ_W   = 22;
  localparam int TICK_W   = 6;
  localparam int LIM_W    = 3;
  localparam int CORE_MAX = 4;            // load fields and mask bits available
  localparam int SUM_W    = 9;            // CORE_MAX * 127 fits
  localparam int CNT_W    = 3;            // 0..CORE_MAX
  localparam int IDX_W    = 2;            // core index
  localparam int FUNC_W   = 2;
  localparam int ACT_W    = 2;
  localparam int REG_W    = 3;

  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_OFF   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ON    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_TOUCH = 2'd3;

  localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_LIMITS = 2'd3;

  localparam logic [REG_W-1:0] REG_LOAD_THR  = 3'd0;
  localparam logic [REG_W-1:0] REG_MIN_CORES = 3'd1;
  localparam logic [REG_W-1:0] REG_UP_TICKS  = 3'd2;
  localparam logic [REG_W-1:0] REG_DN_TICKS  = 3'd3;
  localparam logic [REG_W-1:0] REG_OFF_CORES = 3'd4;
  localparam logic [REG_W-1:0] REG_OFF_FREQ  = 3'd5;
  localparam logic [REG_W-1:0] REG_SAVER     = 3'd6;

  localparam logic [LOAD_W-1:0] RST_LOAD_THR  = 7'd70;
  localparam logic [LIM_W-1:0]  RST_MIN_CORES = 3'd1;
  localparam logic [TICK_W-1:0] RST_UP_TICKS  = 6'd2;
  localparam logic [TICK_W-1:0] RST_DN_TICKS  = 6'd6;
  localparam logic [LIM_W-1:0]  RST_OFF_CORES = 3'd1;
  localparam logic [FREQ_W-1:0] RST_OFF_FREQ  = 22'd1190400;
  localparam logic [FREQ_W-1:0] RST_SAVER     = 22'd729600;
  localparam logic [FREQ_W-1:0] RST_MAX_FREQ  = 22'd2265600;

  localparam logic [LIM_W-1:0] LIM_SAVER_OFF = 3'd1;
  localparam logic [LIM_W-1:0] LIM_SAVER_ON  = 3'd2;
  localparam logic [CNT_W-1:0] TOUCH_CNT     = 3'd2;

  typedef struct packed {
    logic              on;
    logic              cand;
    logic [LOAD_W-1:0] load;
    logic [FREQ_W-1:0] freq;
  } chg_lane_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
    logic             found;
    logic [IDX_W-1:0] idx;
  } chg_merge_t;

  function automatic logic [CNT_W-1:0] pop4(input logic [CORE_MAX-1:0] m);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < CORE_MAX; i++) begin
      n = n + CNT_W'(m[i]);
    end
    return n;
  endfunction

endpackage

/* hw/rtl/chg_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chg_lane
// Per-core lane: gates the core's load by its online bit and flags it as a
// removal candidate when it is online and removable.
// ----------------------------------------------------------------------------
module chg_lane
  import chg_pkg::*;
(
  input  logic              online,
  input  logic              removable,
  input  logic [LOAD_W-1:0] load,
  input  logic [FREQ_W-1:0] freq,
  output chg_lane_t         res
);

  assign res.on   = online;
  assign res.cand = online & removable;
  assign res.load = online ? load : '0;
  assign res.freq = freq;

endmodule

/* hw/rtl/chg_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chg_merge
// Combines the lanes: load sum, online count and lowest-frequency candidate
// (lowest index wins a tie), registered.
// ----------------------------------------------------------------------------
module chg_merge
  import chg_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  chg_lane_t  lanes [CORE_MAX],
  output chg_merge_t res
);

  chg_merge_t res_nxt;
  chg_merge_t res_r;
  logic [FREQ_W-1:0] best_f;

  always_comb begin
    res_nxt = '0;
    best_f  = '0;
    for (int i = 0; i < CORE_MAX; i++) begin
      res_nxt.sum = res_nxt.sum + SUM_W'(lanes[i].load);
      res_nxt.cnt = res_nxt.cnt + CNT_W'(lanes[i].on);
      if (lanes[i].cand && (!res_nxt.found || lanes[i].freq < best_f)) begin
        res_nxt.found = 1'b1;
        res_nxt.idx   = IDX_W'(i);
        best_f        = lanes[i].freq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

/* hw/rtl/chg_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chg_div
// Restoring divider, one quotient bit per cycle, for the mean load.
// A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module chg_div
  import chg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dsr_r;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    trial;

  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign trial   = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      if (shifted >= {1'b0, dsr_r}) begin
        rem_r <= trial[CNT_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[CNT_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = (dsr_r == '0) ? '0 : quo_r;

endmodule

/* hw/rtl/core_hotplug_governor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// core_hotplug_governor
// Hotplug governor: per-core lanes, a merge stage and a serial divider
// decide which core goes on or off line and what frequency cap applies.
// ----------------------------------------------------------------------------
// Flow: the input transfer is captured, the lanes feed the merge register,
// the divider is loaded and runs, and the result is committed to the output
// register once it is free. One item at a time: in_stall is high outside idle.
// The mean load comes from the bit-serial divider (one quotient bit per cycle).
// Reset (synchronous, rst_n low): all managed cores online, timers zero,
// core limits at the core count, caps at 2265600 kHz, registers at defaults.
// ----------------------------------------------------------------------------
module core_hotplug_governor
  import chg_pkg::*;
#(
  parameter int NUM_CORES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  // input item channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [LOAD_W-1:0] in_load_0,
  input  logic [LOAD_W-1:0] in_load_1,
  input  logic [LOAD_W-1:0] in_load_2,
  input  logic [LOAD_W-1:0] in_load_3,
  input  logic [FREQ_W-1:0] in_freq_1,
  input  logic [FREQ_W-1:0] in_freq_2,
  input  logic [FREQ_W-1:0] in_freq_3,
  input  logic [FREQ_W-1:0] in_policy_max,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CORE_MAX-1:0] out_online_mask,
  output logic [FREQ_W-1:0] out_freq_cap,
  output logic [ACT_W-1:0]  out_action,
  output logic [LOAD_W-1:0] out_mean_load,
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [REG_W-1:0]  cfg_index,
  input  logic [FREQ_W-1:0] cfg_data
);

  // Only four cores have load fields and mask bits.
  localparam int CORES = (NUM_CORES > CORE_MAX) ? CORE_MAX : NUM_CORES;
  localparam logic [CORE_MAX-1:0] ALL_MASK = CORE_MAX'((1 << CORES) - 1);
  localparam logic [LIM_W-1:0]    CORES_LIM = LIM_W'(CORES);

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for an input transfer
  localparam logic [2:0] S_MERGE = 3'd1;  // lanes and merge register
  localparam logic [2:0] S_START = 3'd2;  // load the divider
  localparam logic [2:0] S_WAIT  = 3'd3;  // divider running
  localparam logic [2:0] S_DONE  = 3'd4;  // commit state, fill output

  logic [2:0] state_r, state_nxt;

  // configuration registers
  logic [LOAD_W-1:0] load_thr_r;
  logic [LIM_W-1:0]  min_cores_r;
  logic [TICK_W-1:0] up_ticks_r;
  logic [TICK_W-1:0] dn_ticks_r;
  logic [LIM_W-1:0]  off_cores_r;
  logic [FREQ_W-1:0] off_freq_r;
  logic [FREQ_W-1:0] saver_r;

  // governor state
  logic [CORES-1:0]  online_r;
  logic [TICK_W-1:0] up_cnt_r, up_cnt_nxt;
  logic [TICK_W-1:0] dn_cnt_r, dn_cnt_nxt;
  logic [LIM_W-1:0]  lim_r, lim_nxt;
  logic [LIM_W-1:0]  slim_r, slim_nxt;
  logic              flag_r, flag_nxt;
  logic [FREQ_W-1:0] smax_r, smax_nxt;
  logic [FREQ_W-1:0] cap_r, cap_nxt;
  logic [CORE_MAX-1:0] online_nxt;

  // captured item
  logic [FUNC_W-1:0] itm_func_r;
  logic [LOAD_W-1:0] itm_load_r [CORE_MAX];
  logic [FREQ_W-1:0] itm_freq_r [CORE_MAX];
  logic [FREQ_W-1:0] itm_pmax_r;

  // output register
  logic                out_valid_r;
  logic [CORE_MAX-1:0] out_mask_r;
  logic [FREQ_W-1:0]   out_cap_r;
  logic [ACT_W-1:0]    out_act_r;
  logic [LOAD_W-1:0]   out_mean_r;

  logic [ACT_W-1:0]    act_nxt;
  logic [LOAD_W-1:0]   mean_nxt;

  logic accept;
  logic out_free;
  logic commit;

  chg_lane_t  lane_res [CORE_MAX];
  chg_merge_t mrg;
  logic             div_done;
  logic [SUM_W-1:0] div_q;

  logic [CORE_MAX-1:0] online_pad;
  logic [CNT_W-1:0]    cnt_on;
  logic                add_found;
  logic [CORE_MAX-1:0] add_mask;

  assign accept    = in_valid & ~in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = ~out_valid_r | ~out_stall;
  assign commit    = (state_r == S_DONE) & out_free;
  assign cfg_ready = 1'b1;

  assign online_pad = CORE_MAX'(online_r);
  assign cnt_on     = pop4(online_pad);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_MERGE;
      S_MERGE: state_nxt = S_START;
      S_START: state_nxt = S_WAIT;
      S_WAIT:  if (div_done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ------------------------------------------------------------ item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      itm_func_r    <= in_func;
      itm_load_r[0] <= in_load_0;
      itm_load_r[1] <= in_load_1;
      itm_load_r[2] <= in_load_2;
      itm_load_r[3] <= in_load_3;
      itm_freq_r[0] <= '0;       // core 0 is never removed
      itm_freq_r[1] <= in_freq_1;
      itm_freq_r[2] <= in_freq_2;
      itm_freq_r[3] <= in_freq_3;
      itm_pmax_r    <= in_policy_max;
    end
  end

  // ------------------------------------------------------- lanes and merge
  for (genvar g = 0; g < CORE_MAX; g++) begin : g_lane
    if (g < CORES) begin : g_on
      chg_lane u_lane (
        .online    (online_pad[g]),
        .removable (g != 0),
        .load      (itm_load_r[g]),
        .freq      (itm_freq_r[g]),
        .res       (lane_res[g])
      );
    end else begin : g_off
      assign lane_res[g] = '0;
    end
  end

  chg_merge u_merge (
    .clk   (clk),
    .en    (state_r == S_MERGE),
    .lanes (lane_res),
    .res   (mrg)
  );

  chg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_START),
    .dividend (mrg.sum),
    .divisor  (mrg.cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  // lowest-numbered offline core
  always_comb begin
    add_found = 1'b0;
    add_mask  = online_pad;
    for (int i = 0; i < CORE_MAX; i++) begin
      if (ALL_MASK[i] && !online_pad[i] && !add_found) begin
        add_found   = 1'b1;
        add_mask[i] = 1'b1;
      end
    end
  end

  // -------------------------------------------------------- event decision
  always_comb begin
    logic [TICK_W-1:0] up_c;
    logic [TICK_W-1:0] dn_c;
    logic [LIM_W-1:0]  lim_v;
    online_nxt = online_pad;
    up_cnt_nxt = up_cnt_r;
    dn_cnt_nxt = dn_cnt_r;
    lim_nxt    = lim_r;
    slim_nxt   = slim_r;
    flag_nxt   = flag_r;
    smax_nxt   = smax_r;
    cap_nxt    = cap_r;
    act_nxt    = ACT_NONE;
    mean_nxt   = '0;
    up_c       = (up_cnt_r < up_ticks_r) ? up_cnt_r + 1'b1 : up_cnt_r;
    dn_c       = (dn_cnt_r < dn_ticks_r) ? dn_cnt_r + 1'b1 : dn_cnt_r;
    lim_v      = '0;
    case (itm_func_r)
      FUNC_TICK: begin
        mean_nxt   = div_q[LOAD_W-1:0];
        up_cnt_nxt = up_c;
        dn_cnt_nxt = dn_c;
        if (mean_nxt >= load_thr_r && up_c >= up_ticks_r) begin
          up_cnt_nxt = '0;
          dn_cnt_nxt = '0;
          if (LIM_W'(cnt_on) < lim_r && add_found) begin
            online_nxt = add_mask;
            act_nxt    = ACT_ADD;
          end
        end else if (dn_c >= dn_ticks_r) begin
          up_cnt_nxt = '0;
          dn_cnt_nxt = '0;
          if (LIM_W'(cnt_on) > min_cores_r && mrg.found) begin
            online_nxt[mrg.idx] = 1'b0;
            act_nxt             = ACT_REMOVE;
          end
        end
      end
      FUNC_OFF: begin
        smax_nxt = itm_pmax_r;
        if (itm_pmax_r == saver_r) begin
          cap_nxt  = saver_r;
          lim_v    = LIM_SAVER_OFF;
          flag_nxt = 1'b1;
        end else begin
          cap_nxt = off_freq_r;
          if (slim_r > lim_r && flag_r) begin
            flag_nxt = 1'b0;
          end else begin
            slim_nxt = lim_r;
          end
          lim_v = off_cores_r;
        end
        lim_nxt = lim_v;
        // drop cores from core 1 upward until within the new limit
        for (int i = 1; i < CORE_MAX; i++) begin
          if (LIM_W'(pop4(online_nxt)) > lim_v) begin
            online_nxt[i] = 1'b0;
          end
        end
        act_nxt = ACT_LIMITS;
      end
      FUNC_ON: begin
        if (smax_r == saver_r) begin
          cap_nxt = saver_r;
          lim_v   = LIM_SAVER_ON;
        end else begin
          cap_nxt = smax_r;
          lim_v   = slim_r;
        end
        lim_nxt = lim_v;
        // bring cores back from core 0 upward up to the limit
        for (int i = 0; i < CORE_MAX; i++) begin
          if (ALL_MASK[i] && !online_nxt[i] && LIM_W'(pop4(online_nxt)) < lim_v) begin
            online_nxt[i] = 1'b1;
          end
        end
        dn_cnt_nxt = '0;
        act_nxt    = ACT_LIMITS;
      end
      default: begin
        // touch report: add a core only while fewer than two are online
        if (cnt_on < TOUCH_CNT) begin
          up_cnt_nxt = '0;
          dn_cnt_nxt = '0;
          if (LIM_W'(cnt_on) < lim_r && add_found) begin
            online_nxt = add_mask;
            act_nxt    = ACT_ADD;
          end
        end
      end
    endcase
  end

  // ---------------------------------------------------------- state commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      online_r <= ALL_MASK[CORES-1:0];
      up_cnt_r <= '0;
      dn_cnt_r <= '0;
      lim_r    <= CORES_LIM;
      slim_r   <= CORES_LIM;
      flag_r   <= 1'b0;
      smax_r   <= RST_MAX_FREQ;
      cap_r    <= RST_MAX_FREQ;
    end else if (commit) begin
      online_r <= online_nxt[CORES-1:0];
      up_cnt_r <= up_cnt_nxt;
      dn_cnt_r <= dn_cnt_nxt;
      lim_r    <= lim_nxt;
      slim_r   <= slim_nxt;
      flag_r   <= flag_nxt;
      smax_r   <= smax_nxt;
      cap_r    <= cap_nxt;
    end
  end

  // -------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_mask_r <= online_nxt & ALL_MASK;
      out_cap_r  <= cap_nxt;
      out_act_r  <= act_nxt;
      out_mean_r <= mean_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_online_mask = out_mask_r;
  assign out_freq_cap    = out_cap_r;
  assign out_action      = out_act_r;
  assign out_mean_load   = out_mean_r;

  // ------------------------------------------------------ configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_thr_r  <= RST_LOAD_THR;
      min_cores_r <= RST_MIN_CORES;
      up_ticks_r  <= RST_UP_TICKS;
      dn_ticks_r  <= RST_DN_TICKS;
      off_cores_r <= RST_OFF_CORES;
      off_freq_r  <= RST_OFF_FREQ;
      saver_r     <= RST_SAVER;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LOAD_THR:  load_thr_r  <= cfg_data[LOAD_W-1:0];
        REG_MIN_CORES: min_cores_r <= cfg_data[LIM_W-1:0];
        REG_UP_TICKS:  up_ticks_r  <= cfg_data[TICK_W-1:0];
        REG_DN_TICKS:  dn_ticks_r  <= cfg_data[TICK_W-1:0];
        REG_OFF_CORES: off_cores_r <= cfg_data[LIM_W-1:0];
        REG_OFF_FREQ:  off_freq_r  <= cfg_data;
        REG_SAVER:     saver_r     <= cfg_data;
        default: ;     // unmapped index: transfer dropped
      endcase
    end
  end

endmodule
